// File: design/grat_pkg.sv
// grat_pkg: widths, codes and shared types for the guest region address translator
// no dependencies; imported by every module of the block

package grat_pkg;

   // default table depth
   localparam int GRAT_MAX_REGIONS = 8;

   // field widths
   localparam int ADDR_W  = 64;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 4;

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int REG_IDX_W = CSR_AW - 2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_REGIONS_IN_USE = REG_IDX_W'(0);

   // request commands
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_XLATE = 1'b1
   } cmd_type;

   // one request as held in the input register
   typedef struct packed {
      cmd_type             cmd;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   entry_base;
      logic [ADDR_W-1:0]   entry_size;
      logic [ADDR_W-1:0]   entry_host;
      logic [ADDR_W-1:0]   query_addr;
      logic [ADDR_W-1:0]   query_len;
   } req_type;

   // one result
   typedef struct packed {
      logic                hit;
      logic [ADDR_W-1:0]   host_addr;
   } rsp_type;

endpackage

// File: design/guest_region_address_translator.sv
// guest_region_address_translator: top level, request and result registers around the table
// depends on grat_pkg, grat_csr and grat_region_table
//
//  channel   ports                                  direction
//  request   req_valid, req_stall, req_* fields     in
//  result    rsp_valid, rsp_stall, rsp_* fields     out
//  config    psel, penable, pwrite, paddr, ...      in/out
//
// One request per cycle while the result is not stalled; each result passes from the input register
// through the table lookup, which is combinational, into the result register.
// A load writes its slot as it leaves the input register, so the next request sees it.
// Reset clears the count register, the slot usable flags and both valid flags.
// A stalled result holds the result register; the input register fills behind it,
// and req_stall rises only when both registers are full and the result is stalled.

module guest_region_address_translator
   import grat_pkg::*;
#(
   parameter int MAX_REGIONS = GRAT_MAX_REGIONS
)
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [ADDR_W-1:0]    req_entry_base,
   input  logic [ADDR_W-1:0]    req_entry_size,
   input  logic [ADDR_W-1:0]    req_entry_host,
   input  logic [ADDR_W-1:0]    req_query_addr,
   input  logic [ADDR_W-1:0]    req_query_len,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [ADDR_W-1:0]    rsp_host_addr,

   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready
);

   logic               in_vld_ff;
   logic               in_vld_in;
   req_type            in_req_ff;
   logic               out_vld_ff;
   logic               out_vld_in;
   rsp_type            out_rsp_ff;
   rsp_type            lookup_rsp;
   logic               out_adv;
   logic               in_adv;
   logic               req_take;
   logic               load_en;
   logic [COUNT_W-1:0] regions_in_use;

   // handshake control
   assign out_adv   = !out_vld_ff || !rsp_stall;
   assign in_adv    = !in_vld_ff || out_adv;
   assign req_stall = !in_adv;
   assign req_take  = req_valid && in_adv;
   assign load_en   = in_vld_ff && out_adv && (in_req_ff.cmd == CMD_LOAD);

   always_comb begin
      in_vld_in  = in_vld_ff;
      out_vld_in = out_vld_ff;
      if (in_adv) begin
         in_vld_in = req_valid;
      end
      if (out_adv) begin
         out_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.cmd        <= cmd_type'(req_cmd);
         in_req_ff.slot       <= req_slot;
         in_req_ff.entry_base <= req_entry_base;
         in_req_ff.entry_size <= req_entry_size;
         in_req_ff.entry_host <= req_entry_host;
         in_req_ff.query_addr <= req_query_addr;
         in_req_ff.query_len  <= req_query_len;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_adv && in_vld_ff) begin
         out_rsp_ff <= lookup_rsp;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_hit       = out_rsp_ff.hit;
   assign rsp_host_addr = out_rsp_ff.host_addr;

   // register block
   grat_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .regions_in_use (regions_in_use)
   );

   // region table and lookup
   grat_region_table #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_table (
      .clock          (clock),
      .reset          (reset),
      .load_en        (load_en),
      .req            (in_req_ff),
      .regions_in_use (regions_in_use),
      .rsp            (lookup_rsp)
   );

endmodule

// File: design/grat_csr.sv
// grat_csr: APB-style register block holding the regions-in-use count
// depends on grat_pkg

module grat_csr
   import grat_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready,
   output logic [COUNT_W-1:0]   regions_in_use
);

   logic [COUNT_W-1:0]   regions_ff;
   logic [COUNT_W-1:0]   regions_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   // decode
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite && (reg_idx == REG_REGIONS_IN_USE);
   assign pready  = 1'b1;

   // next value of the count register
   always_comb begin
      regions_in = regions_ff;
      if (wr_en) begin
         regions_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regions_ff <= '0;
      end else begin
         regions_ff <= regions_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_REGIONS_IN_USE) begin
         prdata = CSR_DW'(regions_ff);
      end
   end

   assign regions_in_use = regions_ff;

endmodule

// File: design/grat_region_table.sv
// grat_region_table: region slots with per-slot range match and host address select
// depends on grat_pkg

module grat_region_table
   import grat_pkg::*;
#(
   parameter int MAX_REGIONS = GRAT_MAX_REGIONS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_en,
   input  req_type              req,
   input  logic [COUNT_W-1:0]   regions_in_use,
   output rsp_type              rsp
);

   // per-slot storage: guest base, inclusive-exclusive end, host minus base
   logic [ADDR_W-1:0]      base_ff   [MAX_REGIONS];
   logic [ADDR_W-1:0]      limit_ff  [MAX_REGIONS];
   logic [ADDR_W-1:0]      hoff_ff   [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] usable_ff;
   logic [MAX_REGIONS-1:0] usable_in;

   logic [ADDR_W:0]        ld_sum;
   logic                   ld_usable;
   logic [ADDR_W-1:0]      ld_hoff;
   logic [ADDR_W:0]        q_sum;
   logic                   q_ok;
   logic [MAX_REGIONS-1:0] slot_we;
   logic [MAX_REGIONS-1:0] match;
   logic [MAX_REGIONS-1:0] first_hot;
   logic [ADDR_W-1:0]      lane_host [MAX_REGIONS];
   logic [ADDR_W-1:0]      sel_host;

   // load side: end of region, overflow and empty check, host offset
   assign ld_sum    = {1'b0, req.entry_base} + {1'b0, req.entry_size};
   assign ld_usable = !ld_sum[ADDR_W] && (req.entry_size != '0);
   assign ld_hoff   = req.entry_host - req.entry_base;

   // query side: end of range, reject empty or wrapping ranges
   assign q_sum = {1'b0, req.query_addr} + {1'b0, req.query_len};
   assign q_ok  = (req.query_len != '0) && !q_sum[ADDR_W];

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_lane
      // slot write enable
      assign slot_we[i] = load_en && (32'(req.slot) == i);

      always_comb begin
         usable_in[i] = usable_ff[i];
         if (slot_we[i]) begin
            usable_in[i] = ld_usable;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            usable_ff[i] <= 1'b0;
         end else begin
            usable_ff[i] <= usable_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (slot_we[i]) begin
            base_ff[i]  <= req.entry_base;
            limit_ff[i] <= ld_sum[ADDR_W-1:0];
            hoff_ff[i]  <= ld_hoff;
         end
      end

      // containment test and candidate host address
      assign match[i] = usable_ff[i] && (32'(regions_in_use) > i) && q_ok &&
                        (req.query_addr >= base_ff[i]) &&
                        (q_sum[ADDR_W-1:0] <= limit_ff[i]);
      assign lane_host[i] = hoff_ff[i] + req.query_addr;
   end

   // lowest matching slot wins
   assign first_hot = match & (~match + MAX_REGIONS'(1));

   always_comb begin
      sel_host = '0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         sel_host = sel_host | (lane_host[i] & {ADDR_W{first_hot[i]}});
      end
   end

   // loads always report a miss
   always_comb begin
      rsp.hit       = (req.cmd == CMD_XLATE) && (match != '0);
      rsp.host_addr = rsp.hit ? sel_host : '0;
   end

endmodule
